// ===== hdl/ppm_frame_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// ppm frame decoder assertion macros
// shared property forms for the decoder modules
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PPM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppm assertion failed");

// antecedent implies consequent in the next cycle
`define PPM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppm assertion failed");

// condition never holds
`define PPM_ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ppm assertion failed");

`endif

// ===== hdl/ppm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm decoder package
// shared types, codes and reset constants
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int TIME_W  = 16;
    localparam int VALUE_W = 15;
    localparam int CHAN_W  = 3;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 4;

    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [1:0] REG_TIMER_PERIOD   = 2'd0;
    localparam logic [1:0] REG_SYNC_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_CLAMP_LOW      = 2'd2;
    localparam logic [1:0] REG_CLAMP_HIGH     = 2'd3;

    localparam logic [TIME_W-1:0]  RST_TIMER_PERIOD   = 16'd40000;
    localparam logic [TIME_W-1:0]  RST_SYNC_THRESHOLD = 16'd8000;
    localparam logic [VALUE_W-1:0] RST_CLAMP_LOW      = 15'd1000;
    localparam logic [VALUE_W-1:0] RST_CLAMP_HIGH     = 15'd2000;
    localparam logic [TIME_W-1:0]  RST_SLOT_WIDTH     = 16'd2400;

    typedef struct packed {
        logic [TIME_W-1:0]  timer_period;
        logic [TIME_W-1:0]  sync_threshold;
        logic [VALUE_W-1:0] clamp_low;
        logic [VALUE_W-1:0] clamp_high;
    } cfg_t;

    typedef struct packed {
        logic op;
        logic flag;
        logic in_range;
        logic slot_valid;
    } issue_t;

endpackage

// ===== hdl/ppm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm decoder channel interfaces
// input word and result word handshake channels
// ----------------------------------------------------------------------------
interface ppm_in_if
    import ppm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [TIME_W-1:0]   capture_time;
    logic [CHAN_W-1:0]   channel;

    modport source (output valid, output op, output capture_time, output channel,
                    input ready);
    modport sink   (input valid, input op, input capture_time, input channel,
                    output ready);
endinterface

interface ppm_out_if
    import ppm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  channel_value;
    logic                frame_ready;

    modport source (output valid, output channel_value, output frame_ready,
                    input ready);
    modport sink   (input valid, input channel_value, input frame_ready,
                    output ready);
endinterface

// ===== hdl/ppm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ppm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ppm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm configuration registers
// apb write and read access to the four decoder registers
// ----------------------------------------------------------------------------
module ppm_cfg_regs
    import ppm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TIMER_PERIOD:   cfg_next.timer_period   = pwdata[TIME_W-1:0];
                REG_SYNC_THRESHOLD: cfg_next.sync_threshold = pwdata[TIME_W-1:0];
                REG_CLAMP_LOW:      cfg_next.clamp_low      = pwdata[VALUE_W-1:0];
                REG_CLAMP_HIGH:     cfg_next.clamp_high     = pwdata[VALUE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TIMER_PERIOD:   prdata = APB_DW'(cfg_reg.timer_period);
            REG_SYNC_THRESHOLD: prdata = APB_DW'(cfg_reg.sync_threshold);
            REG_CLAMP_LOW:      prdata = APB_DW'(cfg_reg.clamp_low);
            REG_CLAMP_HIGH:     prdata = APB_DW'(cfg_reg.clamp_high);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timer_period   <= RST_TIMER_PERIOD;
            cfg_reg.sync_threshold <= RST_SYNC_THRESHOLD;
            cfg_reg.clamp_low      <= RST_CLAMP_LOW;
            cfg_reg.clamp_high     <= RST_CLAMP_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/ppm_slot_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm slot engine
// gap measurement, slot ram write, frame flag and slot read issue
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_defines.svh"

module ppm_slot_engine
    import ppm_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                accept,
    input  logic                op,
    input  logic [TIME_W-1:0]   capture_time,
    input  logic [CHAN_W-1:0]   channel,
    output issue_t              issue,
    output logic [TIME_W-1:0]   slot_rdata
);

    localparam int AW    = $clog2(CHANNELS);
    localparam int SW    = $clog2(CHANNELS + 1);
    localparam int SLOTS = 1 << AW;

    logic [TIME_W-1:0] last_capture_reg;
    logic [TIME_W-1:0] last_capture_next;
    logic [SW-1:0]     next_slot_reg;
    logic [SW-1:0]     next_slot_next;
    logic              frame_flag_reg;
    logic              frame_flag_next;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOTS-1:0]  slot_valid_next;
    issue_t            issue_reg;
    issue_t            issue_next;

    logic [TIME_W-1:0] gap;
    logic              is_sync;
    logic              slot_free;
    logic              is_capture;
    logic              is_read;
    logic              wr_en;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [SW-1:0]     slot_inc;

    assign is_capture = accept && (op == OP_CAPTURE);
    assign is_read    = accept && (op == OP_READ);
    assign gap        = (capture_time < last_capture_reg)
                        ? capture_time + cfg.timer_period - last_capture_reg
                        : capture_time - last_capture_reg;
    assign is_sync    = gap > cfg.sync_threshold;
    assign slot_free  = next_slot_reg < SW'(CHANNELS);
    assign wr_en      = is_capture && !is_sync && slot_free;
    assign waddr      = AW'(next_slot_reg);
    assign raddr      = AW'(channel);
    assign slot_inc   = next_slot_reg + SW'(1);
    assign issue      = issue_reg;

    always_comb
    begin
        last_capture_next = last_capture_reg;
        next_slot_next    = next_slot_reg;
        frame_flag_next   = frame_flag_reg;
        slot_valid_next   = slot_valid_reg;
        if (is_capture)
        begin
            last_capture_next = capture_time;
            if (is_sync)
            begin
                next_slot_next  = '0;
                frame_flag_next = 1'b1;
            end
            else if (slot_free)
            begin
                next_slot_next  = slot_inc;
                slot_valid_next = slot_valid_reg | (SLOTS'(1) << waddr);
                if (slot_inc == SW'(CHANNELS))
                begin
                    frame_flag_next = 1'b1;
                end
            end
        end
        else if (is_read)
        begin
            frame_flag_next = 1'b0;
        end
    end

    always_comb
    begin
        issue_next.op         = op;
        issue_next.flag       = (op == OP_CAPTURE) ? frame_flag_next : frame_flag_reg;
        issue_next.in_range   = 32'(channel) < CHANNELS;
        issue_next.slot_valid = slot_valid_reg[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_capture_reg <= '0;
            next_slot_reg    <= '0;
            frame_flag_reg   <= 1'b0;
            slot_valid_reg   <= '0;
        end
        else
        begin
            last_capture_reg <= last_capture_next;
            next_slot_reg    <= next_slot_next;
            frame_flag_reg   <= frame_flag_next;
            slot_valid_reg   <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            issue_reg <= issue_next;
        end
    end

    ppm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (CHANNELS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (gap),
        .re    (is_read),
        .raddr (raddr),
        .rdata (slot_rdata)
    );

    `PPM_ASSERT_NEVER(a_slot_bound, next_slot_reg > SW'(CHANNELS))
    `PPM_ASSERT_NEXT(a_last_slot_flag, wr_en && (slot_inc == SW'(CHANNELS)), frame_flag_reg)
    `PPM_ASSERT_NEXT(a_read_clears, is_read, !frame_flag_reg)

endmodule

// ===== hdl/ppm_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm frame decoder
// an accepted word passes the slot ram read stage, then the output register
// throughput: 1 word per cycle unless the output stalls, limited by the single slot ram read port
// a slot read stage and the output register let input run while a result waits
// reset: async active low, registers to defaults, all slots read as 2400
// no clearing pass: per slot valid bits mark written entries
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_defines.svh"

module ppm_frame_decoder
    import ppm_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    ppm_in_if.sink            in_word,
    ppm_out_if.source         out_word
);

    cfg_t               cfg;
    issue_t             issue;
    logic [TIME_W-1:0]  slot_rdata;
    logic               accept;
    logic               s1_adv;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [VALUE_W-1:0] out_value_next;
    logic               out_flag_reg;
    logic [TIME_W-1:0]  raw_width;
    logic [VALUE_W-1:0] half_width;

    assign pready        = 1'b1;
    assign s1_adv        = !out_valid_reg || out_word.ready;
    assign in_word.ready = !s1_valid_reg || s1_adv;
    assign accept        = in_word.valid && in_word.ready;

    assign out_word.valid         = out_valid_reg;
    assign out_word.channel_value = out_value_reg;
    assign out_word.frame_ready   = out_flag_reg;

    ppm_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ppm_slot_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .accept       (accept),
        .op           (in_word.op),
        .capture_time (in_word.capture_time),
        .channel      (in_word.channel),
        .issue        (issue),
        .slot_rdata   (slot_rdata)
    );

    always_comb
    begin
        if (!issue.in_range)
        begin
            raw_width = '0;
        end
        else if (issue.slot_valid)
        begin
            raw_width = slot_rdata;
        end
        else
        begin
            raw_width = RST_SLOT_WIDTH;
        end
        half_width = raw_width[TIME_W-1:1];

        if (issue.op == OP_CAPTURE)
        begin
            out_value_next = '0;
        end
        else if (half_width < cfg.clamp_low)
        begin
            out_value_next = cfg.clamp_low;
        end
        else if (half_width > cfg.clamp_high)
        begin
            out_value_next = cfg.clamp_high;
        end
        else
        begin
            out_value_next = half_width;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_value_reg <= out_value_next;
            out_flag_reg  <= issue.flag;
        end
    end

    `PPM_ASSERT_SAME(a_stall_blocks, s1_valid_reg && out_valid_reg && !out_word.ready, !in_word.ready)
    `PPM_ASSERT_NEXT(a_capture_zero, s1_adv && s1_valid_reg && (issue.op == OP_CAPTURE), out_value_reg == '0)
    `PPM_ASSERT_SAME(a_out_from_s1, $rose(out_valid_reg), $past(s1_valid_reg))

endmodule

// ===== sim/ppm_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm frame decoder testbench
// drives capture and read words through the decoder under random idling and
// stalls, runs an in-bench model of the frame decoding and clamping, and
// checks every result word in order. the register port is reprogrammed
// between phases, with extreme and crossed limits among the settings
// ----------------------------------------------------------------------------
module ppm_frame_decoder_tb
    import ppm_pkg::*;
();

    localparam int N_SLOTS   = 8;
    localparam int LIMIT     = 300000;
    localparam int LONG_HOLD = 400;
    localparam int N_DIR     = 22;
    localparam int PHASE_LEN = 235;

    typedef struct packed {
        logic [VALUE_W-1:0] channel_value;
        logic               frame_ready;
    } ppm_result_t;

    typedef struct packed {
        logic               op;
        logic [TIME_W-1:0]  capture_time;
        logic [CHAN_W-1:0]  channel;
        logic               known;
        logic [VALUE_W-1:0] value;
        logic               flag;
    } dir_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_THIRDS, RX_SPARSE} rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    ppm_in_if  in_bus ();
    ppm_out_if out_bus ();

    ppm_frame_decoder #(.CHANNELS(N_SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_word  (in_bus.sink),
        .out_word (out_bus.source)
    );

    always #5 clk = ~clk;

    // decoder model state
    cfg_t              model_cfg;
    logic [TIME_W-1:0] model_last;
    int                model_slot;
    logic [TIME_W-1:0] model_width [N_SLOTS];
    logic              model_flag;

    ppm_result_t       pending_results [$];
    logic [APB_DW-1:0] apb_rdata;
    int                failures      = 0;
    int                items_sent    = 0;
    int                reads_sent    = 0;
    int                results_seen  = 0;
    int                phases_run    = 0;
    int                burst_left    = 0;
    int                hold_requests = 0;
    int                cycles        = 0;

    // after reset, extremes, wrapped gap, equal threshold, full slots
    dir_row_t dir_rows [N_DIR] = '{
        '{OP_READ,    16'd0,     3'd0, 1'b1, 15'd1200, 1'b0},
        '{OP_READ,    16'd0,     3'd7, 1'b1, 15'd1200, 1'b0},
        '{OP_CAPTURE, 16'd0,     3'd7, 1'b1, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd65535, 3'd0, 1'b1, 15'd0,    1'b1},
        '{OP_CAPTURE, 16'd0,     3'd0, 1'b1, 15'd0,    1'b1},
        '{OP_READ,    16'd65535, 3'd0, 1'b1, 15'd1000, 1'b1},
        '{OP_READ,    16'd0,     3'd0, 1'b1, 15'd1000, 1'b0},
        '{OP_CAPTURE, 16'd8000,  3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd9500,  3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd11000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd12500, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd14000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd15500, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd17000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd18500, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd20000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_READ,    16'd0,     3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_READ,    16'd0,     3'd7, 1'b0, 15'd0,    1'b0},
        '{OP_READ,    16'd0,     3'd3, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd20000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_CAPTURE, 16'd40000, 3'd0, 1'b0, 15'd0,    1'b0},
        '{OP_READ,    16'd0,     3'd1, 1'b0, 15'd0,    1'b0}
    };

    function automatic void reset_decoder();
        model_cfg.timer_period   = RST_TIMER_PERIOD;
        model_cfg.sync_threshold = RST_SYNC_THRESHOLD;
        model_cfg.clamp_low      = RST_CLAMP_LOW;
        model_cfg.clamp_high     = RST_CLAMP_HIGH;
        model_last = '0;
        model_slot = 0;
        model_flag = 1'b0;
        foreach (model_width[i])
            model_width[i] = RST_SLOT_WIDTH;
    endfunction

    function automatic ppm_result_t decode_word(input logic op, input logic [TIME_W-1:0] stamp,
                                                input logic [CHAN_W-1:0] chan);
        ppm_result_t        res;
        logic [TIME_W-1:0]  gap;
        logic [TIME_W-1:0]  raw;
        logic [VALUE_W-1:0] half;
        res = '0;
        if (op == OP_CAPTURE)
        begin
            if (stamp < model_last)
                gap = stamp + model_cfg.timer_period - model_last;
            else
                gap = stamp - model_last;
            if (gap > model_cfg.sync_threshold)
            begin
                model_slot = 0;
                model_flag = 1'b1;
            end
            else if (model_slot < N_SLOTS)
            begin
                model_width[model_slot] = gap;
                model_slot++;
                if (model_slot >= N_SLOTS)
                    model_flag = 1'b1;
            end
            model_last      = stamp;
            res.frame_ready = model_flag;
        end
        else
        begin
            raw  = (int'(chan) < N_SLOTS) ? model_width[chan] : '0;
            half = raw[TIME_W-1:1];
            if (half < model_cfg.clamp_low)
                res.channel_value = model_cfg.clamp_low;
            else if (half > model_cfg.clamp_high)
                res.channel_value = model_cfg.clamp_high;
            else
                res.channel_value = half;
            res.frame_ready = model_flag;
            model_flag      = 1'b0;
        end
        return res;
    endfunction

    // bursts of words with random gaps, sometimes back to back
    task automatic pace();
        int idle;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (idle > 0)
            begin
                @(negedge clk);
                in_bus.valid <= 1'b0;
                repeat (idle - 1) @(negedge clk);
            end
        end
    endtask

    task automatic send_word(input logic op, input logic [TIME_W-1:0] stamp,
                             input logic [CHAN_W-1:0] chan, input logic known,
                             input logic [VALUE_W-1:0] value, input logic flag);
        ppm_result_t predicted;
        @(negedge clk);
        in_bus.valid        <= 1'b1;
        in_bus.op           <= op;
        in_bus.capture_time <= stamp;
        in_bus.channel      <= chan;
        do @(posedge clk); while (!in_bus.ready);
        predicted = decode_word(op, stamp, chan);
        if (known)
        begin
            predicted.channel_value = value;
            predicted.frame_ready   = flag;
        end
        pending_results.push_back(predicted);
        items_sent++;
        if (op == OP_READ)
            reads_sent++;
        pace();
    endtask

    task automatic capture_after(input int gap);
        int nxt;
        nxt = int'(model_last) + gap;
        if (nxt >= int'(model_cfg.timer_period))
            nxt -= int'(model_cfg.timer_period);
        send_word(OP_CAPTURE, nxt[TIME_W-1:0], CHAN_W'($urandom), 1'b0, '0, 1'b0);
    endtask

    task automatic send_read();
        send_word(OP_READ, TIME_W'($urandom), CHAN_W'($urandom_range(0, 7)), 1'b0, '0, 1'b0);
    endtask

    // mostly whole frames with random widths, the rest noise and broken frames
    task automatic run_traffic(input int count);
        int goal;
        int pulses;
        int thr;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            thr = int'(model_cfg.sync_threshold);
            case ($urandom_range(0, 9))
                0: send_word(OP_CAPTURE, TIME_W'($urandom), CHAN_W'($urandom), 1'b0, '0, 1'b0);
                1: send_read();
                default:
                begin
                    if (thr < 65535)
                        capture_after($urandom_range(thr + 1, (thr + 12000 > 65535) ? 65535
                                                                                    : thr + 12000));
                    else
                        capture_after($urandom_range(0, 65535));
                    pulses = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : N_SLOTS;
                    for (int i = 0; i < pulses; i++)
                    begin
                        capture_after($urandom_range(0, (thr < 4400) ? thr : 4400));
                        if ($urandom_range(0, 4) == 0)
                            send_read();
                    end
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic is_write, input logic [1:0] idx,
                             input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apb_rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [APB_DW-1:0] data);
        apb_cycle(1'b1, idx, data);
        case (idx)
            REG_TIMER_PERIOD:   model_cfg.timer_period   = data[TIME_W-1:0];
            REG_SYNC_THRESHOLD: model_cfg.sync_threshold = data[TIME_W-1:0];
            REG_CLAMP_LOW:      model_cfg.clamp_low      = data[VALUE_W-1:0];
            REG_CLAMP_HIGH:     model_cfg.clamp_high     = data[VALUE_W-1:0];
            default: ;
        endcase
        apb_cycle(1'b0, idx, '0);
        if (apb_rdata !== data)
        begin
            $error("register %0d expected %0d got %0d", idx, data, apb_rdata);
            failures++;
        end
    endtask

    task automatic set_config(input int period, input int thr, input int lo, input int hi);
        wait_drained();
        program_reg(REG_TIMER_PERIOD, APB_DW'(period));
        program_reg(REG_SYNC_THRESHOLD, APB_DW'(thr));
        program_reg(REG_CLAMP_LOW, APB_DW'(lo));
        program_reg(REG_CLAMP_HIGH, APB_DW'(hi));
        phases_run++;
    endtask

    // result word checker
    always @(posedge clk)
    begin
        ppm_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_bus.channel_value !== want.channel_value)
                begin
                    $error("channel_value expected %0d got %0d", want.channel_value,
                           out_bus.channel_value);
                    failures++;
                end
                if (out_bus.frame_ready !== want.frame_ready)
                begin
                    $error("frame_ready expected %0d got %0d", want.frame_ready,
                           out_bus.frame_ready);
                    failures++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold on request
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        int       holds_served;
        out_bus.ready = 1'b0;
        mode          = RX_OPEN;
        mode_left     = 0;
        stall_left    = 0;
        holds_served  = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                stall_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   out_bus.ready <= 1'b1;
                    RX_RANDOM: out_bus.ready <= ($urandom_range(0, 2) != 0);
                    RX_THIRDS: out_bus.ready <= (mode_left % 3 == 0);
                    default:   out_bus.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", LIMIT);
        $display("ppm_frame_decoder: mismatch");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_bus.valid        = 1'b0;
        in_bus.op           = OP_CAPTURE;
        in_bus.capture_time = '0;
        in_bus.channel      = '0;
        reset_decoder();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].capture_time, dir_rows[i].channel,
                      dir_rows[i].known, dir_rows[i].value, dir_rows[i].flag);
        run_traffic(PHASE_LEN);

        set_config(20000, 3000, 500, 1000);
        hold_requests++;
        run_traffic(PHASE_LEN);
        set_config(65535, 65535, 0, 32767);
        run_traffic(PHASE_LEN);
        // crossed limits, tiny timer period, any nonzero gap counts as sync
        set_config(2, 0, 32767, 0);
        run_traffic(PHASE_LEN);
        set_config(50000, 6000, 1500, 900);
        run_traffic(PHASE_LEN);
        set_config($urandom_range(2, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 32767), $urandom_range(0, 32767));
        hold_requests++;
        run_traffic(PHASE_LEN);
        set_config($urandom_range(2, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 32767), $urandom_range(0, 32767));
        run_traffic(PHASE_LEN);
        set_config(40000, 8000, 1000, 2000);
        run_traffic(PHASE_LEN);

        wait_drained();
        $display("%0d words in (%0d reads), %0d results checked", items_sent, reads_sent,
                 results_seen);
        $display("%0d register settings, %0d long receiver holds", phases_run, hold_requests);
        if (failures == 0)
            $display("ppm_frame_decoder: match");
        else
            $display("ppm_frame_decoder: mismatch");
        $finish;
    end

endmodule
